/* hdl/assert_macros.svh */
// Assertion helpers for the RTL files; the core file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that cond at one edge implies prop at the next edge.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* hdl/xfv_pkg.sv */
package xfv_pkg;

   // Reset values of the configuration registers.
   localparam logic [7:0] HEADER_FIRST_RESET   = 8'hAA;
   localparam logic [7:0] HEADER_SECOND_RESET  = 8'h55;
   localparam logic [7:0] TRAILER_FIRST_RESET  = 8'h55;
   localparam logic [7:0] TRAILER_SECOND_RESET = 8'hAA;

   // Configuration register indexes.
   localparam logic [1:0] REG_HEADER_FIRST   = 2'd0;
   localparam logic [1:0] REG_HEADER_SECOND  = 2'd1;
   localparam logic [1:0] REG_TRAILER_FIRST  = 2'd2;
   localparam logic [1:0] REG_TRAILER_SECOND = 2'd3;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR2,
      PH_LEN,
      PH_DATA,
      PH_CHECK,
      PH_TRL1,
      PH_TRL2
   } phase_type;

   typedef enum logic [1:0] {
      ST_VALID        = 2'd0,
      ST_HEADER_ERR   = 2'd1,
      ST_TRAILER_ERR  = 2'd2,
      ST_PARITY_ERR   = 2'd3
   } status_type;

   // Expected framing bytes.
   typedef struct packed {
      logic [7:0] header_first;
      logic [7:0] header_second;
      logic [7:0] trailer_first;
      logic [7:0] trailer_second;
   } cfg_type;

   // One frame status item.
   typedef struct packed {
      status_type status;
      logic [7:0] data_length;
   } rsp_type;

endpackage

/* hdl/xfv_frame_fsm.sv */
module xfv_frame_fsm (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       item_byte,
   input  logic             item_start,
   input  xfv_pkg::cfg_type cfg,
   output logic             res_valid,
   output xfv_pkg::rsp_type res
);

   xfv_pkg::phase_type phase_ff, phase_in;
   logic [7:0] length_seen_ff, length_seen_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] parity_ff, parity_in;
   logic       parity_bad_ff, parity_bad_in;
   logic       trailer_bad_ff, trailer_bad_in;
   logic       trailer_bad_now;

   // Frame state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= xfv_pkg::PH_IDLE;
         length_seen_ff <= 8'd0;
         bytes_left_ff  <= 8'd0;
         parity_ff      <= 8'd0;
         parity_bad_ff  <= 1'b0;
         trailer_bad_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         length_seen_ff <= length_seen_in;
         bytes_left_ff  <= bytes_left_in;
         parity_ff      <= parity_in;
         parity_bad_ff  <= parity_bad_in;
         trailer_bad_ff <= trailer_bad_in;
      end
   end

   assign trailer_bad_now = trailer_bad_ff || (item_byte != cfg.trailer_second);

   // Next state and status for one byte.
   always_comb begin
      phase_in       = phase_ff;
      length_seen_in = length_seen_ff;
      bytes_left_in  = bytes_left_ff;
      parity_in      = parity_ff;
      parity_bad_in  = parity_bad_ff;
      trailer_bad_in = trailer_bad_ff;
      res_valid      = 1'b0;
      res.status     = xfv_pkg::ST_VALID;
      res.data_length = length_seen_ff;
      if (step) begin
         if (item_start) begin
            // A start flag abandons any frame in progress.
            length_seen_in = 8'd0;
            bytes_left_in  = 8'd0;
            parity_in      = 8'd0;
            parity_bad_in  = 1'b0;
            trailer_bad_in = 1'b0;
            if (item_byte != cfg.header_first) begin
               res_valid       = 1'b1;
               res.status      = xfv_pkg::ST_HEADER_ERR;
               res.data_length = 8'd0;
               phase_in        = xfv_pkg::PH_IDLE;
            end else begin
               phase_in = xfv_pkg::PH_HDR2;
            end
         end else begin
            unique case (phase_ff)
               xfv_pkg::PH_HDR2: begin
                  if (item_byte != cfg.header_second) begin
                     res_valid       = 1'b1;
                     res.status      = xfv_pkg::ST_HEADER_ERR;
                     res.data_length = 8'd0;
                     phase_in        = xfv_pkg::PH_IDLE;
                  end else begin
                     phase_in = xfv_pkg::PH_LEN;
                  end
               end
               xfv_pkg::PH_LEN: begin
                  length_seen_in = item_byte;
                  bytes_left_in  = item_byte;
                  parity_in      = item_byte;
                  phase_in = (item_byte == 8'd0) ? xfv_pkg::PH_CHECK : xfv_pkg::PH_DATA;
               end
               xfv_pkg::PH_DATA: begin
                  parity_in     = parity_ff ^ item_byte;
                  bytes_left_in = bytes_left_ff - 8'd1;
                  if (bytes_left_ff == 8'd1) begin
                     phase_in = xfv_pkg::PH_CHECK;
                  end
               end
               xfv_pkg::PH_CHECK: begin
                  parity_bad_in = (item_byte != parity_ff);
                  phase_in      = xfv_pkg::PH_TRL1;
               end
               xfv_pkg::PH_TRL1: begin
                  trailer_bad_in = (item_byte != cfg.trailer_first);
                  phase_in       = xfv_pkg::PH_TRL2;
               end
               xfv_pkg::PH_TRL2: begin
                  // Trailer errors take precedence over parity errors.
                  trailer_bad_in = trailer_bad_now;
                  res_valid      = 1'b1;
                  phase_in       = xfv_pkg::PH_IDLE;
                  if (trailer_bad_now) begin
                     res.status = xfv_pkg::ST_TRAILER_ERR;
                  end else if (parity_bad_ff) begin
                     res.status = xfv_pkg::ST_PARITY_ERR;
                  end else begin
                     res.status = xfv_pkg::ST_VALID;
                  end
               end
               default: begin
                  // Bytes between frames are dropped.
                  phase_in = xfv_pkg::PH_IDLE;
               end
            endcase
         end
      end
   end

endmodule

/* hdl/xfv_rsp_buffer.sv */
module xfv_rsp_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  xfv_pkg::rsp_type push_data,
   input  logic             pop,
   output logic             has_space,
   output logic             head_valid,
   output xfv_pkg::rsp_type head
);

   logic [1:0]       count_ff, count_in;
   xfv_pkg::rsp_type entry0_ff, entry0_in;
   xfv_pkg::rsp_type entry1_ff, entry1_in;

   assign has_space  = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head       = entry0_ff;

   // Count is control state; entries hold payload only.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
   end

   // Two-entry queue, head in entry 0.
   always_comb begin
      count_in  = count_ff;
      entry0_in = entry0_ff;
      entry1_in = entry1_ff;
      if (push && pop) begin
         entry0_in = push_data;
      end else if (push) begin
         count_in = count_ff + 2'd1;
         if (count_ff == 2'd0) begin
            entry0_in = push_data;
         end else begin
            entry1_in = push_data;
         end
      end else if (pop) begin
         count_in  = count_ff - 2'd1;
         entry0_in = entry1_ff;
      end
   end

endmodule

/* hdl/xor_frame_validator_core.sv */
// Channel  | Direction | Handshake          | Payload
// req      | in        | req_valid/stall    | req_frame_byte, req_frame_start
// rsp      | out       | rsp_valid/stall    | rsp_status, rsp_data_length
// csr      | in        | csr_write_enable   | csr_index, csr_write_data
//
// One byte item is taken per cycle while req is not stalled; a status passes through the input
// register and the two-entry result queue after the byte that ends the frame.
// Synchronous active-high reset restores the default framing bytes and returns to idle.
// A stall on rsp is absorbed by the two-entry queue; req stalls only when it is full.
`include "assert_macros.svh"

module xor_frame_validator_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_frame_byte,
   input  logic       req_frame_start,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_data_length,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_write_data
);

   xfv_pkg::cfg_type cfg_ff, cfg_in;
   logic             item_valid_ff, item_valid_in;
   logic [7:0]       item_byte_ff, item_byte_in;
   logic             item_start_ff, item_start_in;
   logic             req_accept;
   logic             advance;
   logic             has_space;
   logic             res_valid;
   xfv_pkg::rsp_type res;
   xfv_pkg::rsp_type head;

   // Configuration registers.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            xfv_pkg::REG_HEADER_FIRST:   cfg_in.header_first   = csr_write_data;
            xfv_pkg::REG_HEADER_SECOND:  cfg_in.header_second  = csr_write_data;
            xfv_pkg::REG_TRAILER_FIRST:  cfg_in.trailer_first  = csr_write_data;
            xfv_pkg::REG_TRAILER_SECOND: cfg_in.trailer_second = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_first   <= xfv_pkg::HEADER_FIRST_RESET;
         cfg_ff.header_second  <= xfv_pkg::HEADER_SECOND_RESET;
         cfg_ff.trailer_first  <= xfv_pkg::TRAILER_FIRST_RESET;
         cfg_ff.trailer_second <= xfv_pkg::TRAILER_SECOND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Input register; the held item moves on when the queue has room.
   assign advance    = item_valid_ff && has_space;
   assign req_stall  = item_valid_ff && !has_space;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      item_valid_in = item_valid_ff;
      item_byte_in  = item_byte_ff;
      item_start_in = item_start_ff;
      if (req_accept) begin
         item_valid_in = 1'b1;
         item_byte_in  = req_frame_byte;
         item_start_in = req_frame_start;
      end else if (advance) begin
         item_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_byte_ff  <= item_byte_in;
      item_start_ff <= item_start_in;
   end

   xfv_frame_fsm u_frame_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .item_byte  (item_byte_ff),
      .item_start (item_start_ff),
      .cfg        (cfg_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   xfv_rsp_buffer u_rsp_buffer (
      .clock      (clock),
      .reset      (reset),
      .push       (res_valid),
      .push_data  (res),
      .pop        (rsp_valid && !rsp_stall),
      .has_space  (has_space),
      .head_valid (rsp_valid),
      .head       (head)
   );

   assign rsp_status      = head.status;
   assign rsp_data_length = head.data_length;

   // A header error never reports a length.
   `ASSERT_CLK(a_hdr_err_len, clock, reset, (!(rsp_valid && rsp_status == xfv_pkg::ST_HEADER_ERR) || rsp_data_length == 8'd0), "header error with nonzero length")

   // An item blocked in the input register is kept.
   `ASSERT_NEXT(a_item_held, clock, reset, item_valid_ff && !has_space, item_valid_ff, "held item lost")

   // A write to the first header register takes effect on the next cycle.
   `ASSERT_NEXT(a_csr_write, clock, reset, csr_write_enable && csr_index == xfv_pkg::REG_HEADER_FIRST, cfg_ff.header_first == $past(csr_write_data), "header register not written")

endmodule
